// File: design/cdg_pkg.sv
package cdg_pkg;

	// configuration register indexes
	localparam logic [0:0] REG_LINE_LENGTH = 1'd0;
	localparam logic [0:0] REG_LINE_COUNT  = 1'd1;

	// field and register widths fixed by the interface
	localparam int LEN_W     = 11;
	localparam int LINE_W    = 16;
	localparam int COL_OUT_W = 10;
	localparam int CFG_W     = 16;

	localparam logic [LEN_W-1:0]  LEN_RESET = 11'd512;
	localparam logic [LINE_W-1:0] CNT_RESET = 16'd512;

	// smallest legal line length and line count
	localparam int MIN_DIM = 3;

	// result slots produced by one pixel, in emit order
	localparam int RES_N     = 3;
	localparam int RES_PRIOR = 0;   // result for the previous line
	localparam int RES_TAIL  = 1;   // last line, column one back
	localparam int RES_LAST  = 2;   // last line, last column, closes image

	typedef logic [RES_N-1:0] pend_t;

	// sequencer load request from the datapath
	typedef struct packed {
		logic  load;
		pend_t pend;
	} seq_ctl_t;

	// sequencer status back to the datapath
	typedef struct packed {
		logic full;
		logic retire;
	} seq_st_t;

endpackage

// File: design/central_difference_gradient_unit.sv
// Channel  | handshake                | payload
// ---------+--------------------------+--------------------------------------------
// in       | in_valid / in_stall      | pixel
// out      | out_valid / out_stall    | line_index, column_index, grad_across,
//          |                          | grad_along, image_done
// cfg      | cfg_wr_en                | cfg_index, cfg_wr_data
//
// One pixel per cycle unless in_stall; words pass the result stage, then the output register.
// On the last line every pixel but the first gives two or three words, so input stalls
// there; the single output register paces that flush.
// Line stores are two dual-read memories, read at accept and written back on retire,
// with a bypass for the entry written in the same cycle.
// Reset clears counters, recent pixels and control flags; data and line stores are not cleared.
module central_difference_gradient_unit
	import cdg_pkg::*;
#(
	parameter int MAX_LINE   = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [0:0]                     cfg_index,
	input  logic [CFG_W-1:0]               cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [PIXEL_BITS-1:0]   pixel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [LINE_W-1:0]              line_index,
	output logic [COL_OUT_W-1:0]           column_index,
	output logic signed [PIXEL_BITS:0]     grad_across,
	output logic signed [PIXEL_BITS:0]     grad_along,
	output logic                           image_done
);

	localparam int AW = $clog2(MAX_LINE);
	localparam int CW = $clog2(MAX_LINE + 1);
	localparam int PB = PIXEL_BITS;
	localparam int GW = PIXEL_BITS + 1;

	// configuration
	logic [LEN_W-1:0]  len_q;
	logic [LINE_W-1:0] cnt_q;

	// position and recent pixels
	logic [AW-1:0]     col_q;
	logic [LINE_W-1:0] line_q;
	logic [PB-1:0]     recent0_q;
	logic [PB-1:0]     recent1_q;

	// accept stage
	logic              in_acc;
	logic [CW-1:0]     len_eff;
	logic [CW-1:0]     len_m1;
	logic [LINE_W-1:0] cnt_m1;
	logic              last_col;
	logic              last_line;
	logic [AW-1:0]     j0;
	logic [AW-1:0]     jm0;
	logic [AW-1:0]     jp0;
	logic [LINE_W-1:0] ri0;
	pend_t             pend0;
	logic              en_across0;
	logic              en_along_a0;
	logic              en_along_b0;

	// result stage
	logic [AW-1:0]     j_s1;
	logic [LINE_W-1:0] line_s1;
	logic [LINE_W-1:0] ri_s1;
	logic [PB-1:0]     px_s1;
	logic [PB-1:0]     prev2_s1;
	logic              en_across_s1;
	logic              en_along_a_s1;
	logic              en_along_b_s1;
	logic              fwd_oj_s1;
	logic              fwd_ojm_s1;
	logic              fwd_nj_s1;
	logic              fwd_njp_s1;
	logic [PB-1:0]     byp_older_q;
	logic [PB-1:0]     byp_newer_q;

	logic [PB-1:0]     rd_oj;
	logic [PB-1:0]     rd_ojm;
	logic [PB-1:0]     rd_nj;
	logic [PB-1:0]     rd_njp;
	logic [PB-1:0]     older_j;
	logic [PB-1:0]     older_jm;
	logic [PB-1:0]     newer_j;
	logic [PB-1:0]     newer_jp;
	logic [GW-1:0]     across;
	logic [GW-1:0]     along_a;
	logic [GW-1:0]     along_b;

	seq_ctl_t          ctl;
	seq_st_t           st;

	logic [RES_N-1:0][LINE_W-1:0]    cand_line;
	logic [RES_N-1:0][COL_OUT_W-1:0] cand_col;
	logic [RES_N-1:0][GW-1:0]        cand_across;
	logic [RES_N-1:0][GW-1:0]        cand_along;
	logic [RES_N-1:0]                cand_done;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			cnt_q <= CNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_LENGTH: len_q <= cfg_wr_data[LEN_W-1:0];
				REG_LINE_COUNT:  cnt_q <= cfg_wr_data[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// take a pixel whenever the result stage is free or leaving
	assign in_stall = st.full && !st.retire;
	assign in_acc   = in_valid && !in_stall;

	// clamp registers and place the pixel
	always_comb begin
		if (32'(len_q) > MAX_LINE) begin
			len_eff = CW'(MAX_LINE);
		end else if (32'(len_q) < MIN_DIM) begin
			len_eff = CW'(MIN_DIM);
		end else begin
			len_eff = CW'(len_q);
		end
		len_m1    = len_eff - CW'(1);
		cnt_m1    = ((cnt_q < LINE_W'(MIN_DIM)) ? LINE_W'(MIN_DIM) : cnt_q) - LINE_W'(1);
		last_col  = CW'(col_q) >= len_m1;
		last_line = line_q >= cnt_m1;
		j0        = last_col ? AW'(len_m1) : col_q;
		jm0       = j0 - AW'(1);
		jp0       = j0 + AW'(1);
		ri0       = line_q - LINE_W'(1);

		en_across0  = (ri0 != '0) && (ri0 < cnt_m1);
		en_along_a0 = (j0 != '0) && (CW'(j0) < len_m1);
		en_along_b0 = (jm0 != '0) && (CW'(jm0) < len_m1);

		pend0            = '0;
		pend0[RES_PRIOR] = line_q != '0;
		pend0[RES_TAIL]  = last_line && (j0 != '0);
		pend0[RES_LAST]  = last_line && last_col;
	end

	// advance position, shift recent pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			line_q    <= '0;
			recent0_q <= '0;
			recent1_q <= '0;
		end else if (in_acc) begin
			recent1_q <= recent0_q;
			recent0_q <= pixel;
			if (last_col) begin
				col_q  <= '0;
				line_q <= last_line ? '0 : line_q + LINE_W'(1);
			end else begin
				col_q <= j0 + AW'(1);
			end
		end
	end

	// load result stage, note bypasses against the word written this cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			j_s1          <= j0;
			line_s1       <= line_q;
			ri_s1         <= ri0;
			px_s1         <= pixel;
			prev2_s1      <= recent1_q;
			en_across_s1  <= en_across0;
			en_along_a_s1 <= en_along_a0;
			en_along_b_s1 <= en_along_b0;
			fwd_oj_s1     <= st.retire && (j_s1 == j0);
			fwd_ojm_s1    <= st.retire && (j_s1 == jm0);
			fwd_nj_s1     <= st.retire && (j_s1 == j0);
			fwd_njp_s1    <= st.retire && (j_s1 == jp0);
			byp_older_q   <= newer_j;
			byp_newer_q   <= px_s1;
		end
	end

	// line stores: older takes newer at j, newer takes the pixel
	cdg_line_mem #(
		.DEPTH (MAX_LINE),
		.WIDTH (PB)
	) u_older (
		.clk     (clk),
		.we      (st.retire),
		.waddr   (j_s1),
		.wdata   (newer_j),
		.re      (in_acc),
		.raddr_a (j0),
		.raddr_b (jm0),
		.rdata_a (rd_oj),
		.rdata_b (rd_ojm)
	);

	cdg_line_mem #(
		.DEPTH (MAX_LINE),
		.WIDTH (PB)
	) u_newer (
		.clk     (clk),
		.we      (st.retire),
		.waddr   (j_s1),
		.wdata   (px_s1),
		.re      (in_acc),
		.raddr_a (j0),
		.raddr_b (jp0),
		.rdata_a (rd_nj),
		.rdata_b (rd_njp)
	);

	// apply bypass on read data
	assign older_j  = fwd_oj_s1  ? byp_older_q : rd_oj;
	assign older_jm = fwd_ojm_s1 ? byp_older_q : rd_ojm;
	assign newer_j  = fwd_nj_s1  ? byp_newer_q : rd_nj;
	assign newer_jp = fwd_njp_s1 ? byp_newer_q : rd_njp;

	// half-unit differences, zero on border lines and columns
	assign across  = en_across_s1
		? {older_j[PB-1], older_j} - {px_s1[PB-1], px_s1} : '0;
	assign along_a = en_along_a_s1
		? {older_jm[PB-1], older_jm} - {newer_jp[PB-1], newer_jp} : '0;
	assign along_b = en_along_b_s1
		? {prev2_s1[PB-1], prev2_s1} - {px_s1[PB-1], px_s1} : '0;

	// candidate words for each result slot
	always_comb begin
		cand_line[RES_PRIOR]   = ri_s1;
		cand_col[RES_PRIOR]    = COL_OUT_W'(j_s1);
		cand_across[RES_PRIOR] = across;
		cand_along[RES_PRIOR]  = along_a;
		cand_done[RES_PRIOR]   = 1'b0;

		cand_line[RES_TAIL]    = line_s1;
		cand_col[RES_TAIL]     = COL_OUT_W'(j_s1 - AW'(1));
		cand_across[RES_TAIL]  = '0;
		cand_along[RES_TAIL]   = along_b;
		cand_done[RES_TAIL]    = 1'b0;

		cand_line[RES_LAST]    = line_s1;
		cand_col[RES_LAST]     = COL_OUT_W'(j_s1);
		cand_across[RES_LAST]  = '0;
		cand_along[RES_LAST]   = '0;
		cand_done[RES_LAST]    = 1'b1;
	end

	assign ctl.load = in_acc;
	assign ctl.pend = pend0;

	cdg_seq #(
		.GW (GW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.st           (st),
		.cand_line    (cand_line),
		.cand_col     (cand_col),
		.cand_across  (cand_across),
		.cand_along   (cand_along),
		.cand_done    (cand_done),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_index   (line_index),
		.column_index (column_index),
		.grad_across  (grad_across),
		.grad_along   (grad_along),
		.image_done   (image_done)
	);

`ifndef SYNTHESIS
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < MAX_LINE)
		else $error("column counter past line store depth");
	a_image_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_col && last_line) |=> (col_q == '0 && line_q == '0))
		else $error("position not cleared after last pixel");
	a_bypass_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !st.retire) |=> !(fwd_oj_s1 || fwd_ojm_s1 || fwd_nj_s1 || fwd_njp_s1))
		else $error("bypass set with no write-back");
`endif

endmodule

// File: design/cdg_line_mem.sv
module cdg_line_mem
	import cdg_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, read two with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: design/cdg_seq.sv
module cdg_seq
	import cdg_pkg::*;
#(
	parameter int GW = 17
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  seq_ctl_t                          ctl,
	output seq_st_t                           st,
	input  logic [RES_N-1:0][LINE_W-1:0]      cand_line,
	input  logic [RES_N-1:0][COL_OUT_W-1:0]   cand_col,
	input  logic [RES_N-1:0][GW-1:0]          cand_across,
	input  logic [RES_N-1:0][GW-1:0]          cand_along,
	input  logic [RES_N-1:0]                  cand_done,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [LINE_W-1:0]                 line_index,
	output logic [COL_OUT_W-1:0]              column_index,
	output logic signed [GW-1:0]              grad_across,
	output logic signed [GW-1:0]              grad_along,
	output logic                              image_done
);

	logic        full_q;
	pend_t       pend_q;
	logic        out_valid_q;
	logic [1:0]  sel_idx;
	pend_t       sel_mask;
	pend_t       rest;
	logic        out_free;
	logic        ld;
	logic        retire;

	// pick the lowest pending result slot
	always_comb begin
		sel_idx  = 2'(RES_LAST);
		sel_mask = '0;
		if (pend_q[RES_PRIOR]) begin
			sel_idx = 2'(RES_PRIOR);
		end else if (pend_q[RES_TAIL]) begin
			sel_idx = 2'(RES_TAIL);
		end
		sel_mask[sel_idx] = pend_q[sel_idx];
	end

	assign rest     = pend_q & ~sel_mask;
	assign out_free = !out_valid_q || !out_stall;
	assign ld       = full_q && (pend_q != '0) && out_free;
	assign retire   = full_q && ((pend_q == '0) || (ld && rest == '0));

	assign st.full   = full_q;
	assign st.retire = retire;

	// hold the item, drop each result slot as its word goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			pend_q <= '0;
		end else if (ctl.load) begin
			full_q <= 1'b1;
			pend_q <= ctl.pend;
		end else if (retire) begin
			full_q <= 1'b0;
			pend_q <= '0;
		end else if (ld) begin
			pend_q <= rest;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (ld) begin
			line_index   <= cand_line[sel_idx];
			column_index <= cand_col[sel_idx];
			grad_across  <= cand_across[sel_idx];
			grad_along   <= cand_along[sel_idx];
			image_done   <= cand_done[sel_idx];
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (!full_q || retire))
		else $error("item loaded over a busy stage");
	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled output word dropped");
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> $onehot(sel_mask))
		else $error("output select not one-hot");
`endif

endmodule

// File: tb/tb_central_difference_gradient_unit.sv
module tb_central_difference_gradient_unit;
	import cdg_pkg::*;

	localparam int PIX_W        = 16;
	localparam int GRAD_W       = PIX_W + 1;
	localparam int STORE_DEPTH  = 1024;
	localparam int SETTLE       = 16;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 300;
	localparam int PRINT_CAP    = 40;

	typedef struct {
		logic [LINE_W-1:0]        line;
		logic [COL_OUT_W-1:0]     column;
		logic signed [GRAD_W-1:0] across;
		logic signed [GRAD_W-1:0] along;
		logic                     done;
	} gradient_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [0:0]               cfg_index = REG_LINE_LENGTH;
	logic [CFG_W-1:0]         cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [PIX_W-1:0]  pixel = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [LINE_W-1:0]        line_index;
	logic [COL_OUT_W-1:0]     column_index;
	logic signed [GRAD_W-1:0] grad_across;
	logic signed [GRAD_W-1:0] grad_along;
	logic                     image_done;

	// shadow of the block: registers, line stores, recent pixels, position
	logic [LEN_W-1:0]         line_length_reg = LEN_RESET;
	logic [LINE_W-1:0]        line_count_reg = CNT_RESET;
	logic signed [PIX_W-1:0]  older_line[STORE_DEPTH];
	logic signed [PIX_W-1:0]  newer_line[STORE_DEPTH];
	logic signed [PIX_W-1:0]  prev_pixel[2];
	int                       line_pos = 0;
	int                       col_pos = 0;

	gradient_word_t           expected_words[$];
	int                       mismatch_count = 0;
	int                       cycle_count = 0;
	bit                       sender_quiet = 1'b0;
	bit                       receiver_quiet = 1'b0;
	int                       stall_run = 0;
	bit                       stall_next = 1'b0;

	central_difference_gradient_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_index   (line_index),
		.column_index (column_index),
		.grad_across  (grad_across),
		.grad_along   (grad_along),
		.image_done   (image_done)
	);

	always #4 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int eff_length();
		int len;
		len = int'(line_length_reg);
		if (len < MIN_DIM) len = MIN_DIM;
		if (len > STORE_DEPTH) len = STORE_DEPTH;
		return len;
	endfunction

	function automatic int eff_count();
		int cnt;
		cnt = int'(line_count_reg);
		if (cnt < MIN_DIM) cnt = MIN_DIM;
		return cnt;
	endfunction

	function automatic void push_word(int line, int col, int across, int along, bit done);
		gradient_word_t w;
		w.line   = line[LINE_W-1:0];
		w.column = col[COL_OUT_W-1:0];
		w.across = across[GRAD_W-1:0];
		w.along  = along[GRAD_W-1:0];
		w.done   = done;
		expected_words.push_back(w);
	endfunction

	// work out the words one accepted pixel releases and advance the shadow
	function automatic void predict_gradients(logic signed [PIX_W-1:0] px);
		int  len, cnt, i, j, across, along;
		bit  last_col, last_line;
		len = eff_length();
		cnt = eff_count();
		i = line_pos;
		j = (col_pos > len - 1) ? len - 1 : col_pos;
		last_col = (col_pos >= len - 1);
		last_line = (i >= cnt - 1);

		// word for the line above, now that its lower neighbor is here
		if (i >= 1) begin
			across = 0;
			along = 0;
			if (i - 1 >= 1 && i - 1 < cnt - 1)
				across = int'(older_line[j]) - int'(px);
			if (j >= 1 && j < len - 1)
				along = int'(older_line[j-1]) - int'(newer_line[j+1]);
			push_word(i - 1, j, across, along, 1'b0);
		end

		older_line[j] = newer_line[j];
		newer_line[j] = px;

		// flush the last line as it arrives
		if (last_line) begin
			if (j >= 1) begin
				along = 0;
				if (j - 1 >= 1 && j - 1 < len - 1)
					along = int'(prev_pixel[1]) - int'(px);
				push_word(i, j - 1, 0, along, 1'b0);
			end
			if (last_col)
				push_word(i, j, 0, 0, 1'b1);
		end

		prev_pixel[1] = prev_pixel[0];
		prev_pixel[0] = px;

		if (last_col) begin
			col_pos = 0;
			line_pos = last_line ? 0 : ((i + 1) & 32'hFFFF);
		end else begin
			col_pos = j + 1;
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch %s: got %0d, expected %0d (cycle %0d)",
				what, got, want, cycle_count);
	endtask

	// check each accepted word against the oldest prediction
	always @(posedge clk) begin
		gradient_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word, line_index", longint'(line_index), -1);
			end else begin
				w = expected_words.pop_front();
				if (line_index !== w.line)
					report_mismatch("line_index", longint'(line_index), longint'(w.line));
				if (column_index !== w.column)
					report_mismatch("column_index", longint'(column_index),
						longint'(w.column));
				if (grad_across !== w.across)
					report_mismatch("grad_across", longint'(grad_across),
						longint'(w.across));
				if (grad_along !== w.along)
					report_mismatch("grad_along", longint'(grad_along), longint'(w.along));
				if (image_done !== w.done)
					report_mismatch("image_done", longint'(image_done), longint'(w.done));
			end
		end
	end

	// stall the output in bursts, mostly short
	always @(negedge clk) begin
		if (stall_run == 0) begin
			if ($urandom_range(0, 99) < 35) begin
				stall_next = 1'b1;
				stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
					: $urandom_range(1, 3);
			end else begin
				stall_next = 1'b0;
				stall_run = $urandom_range(1, 8);
			end
		end
		stall_run--;
		out_stall <= stall_next && !receiver_quiet;
	end

	function automatic int pick_gap();
		int r;
		if (sender_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 12);
	endfunction

	function automatic logic signed [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 19))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return PIX_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// offer one pixel, hold it until taken, then predict
	task automatic send_pixel(input logic signed [PIX_W-1:0] px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		do
			@(posedge clk);
		while (in_stall);
		predict_gradients(px);
		@(negedge clk);
	endtask

	// hold input until every predicted word has come out, then settle
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_LINE_LENGTH)
			line_length_reg = data[LEN_W-1:0];
		else
			line_count_reg = data[LINE_W-1:0];
		@(negedge clk);
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] len_word, input logic [CFG_W-1:0] cnt_word);
		wait_for_results();
		write_reg(REG_LINE_LENGTH, len_word);
		write_reg(REG_LINE_COUNT, cnt_word);
	endtask

	task automatic send_random_image();
		int n;
		n = eff_length() * eff_count();
		repeat (n) begin
			// now and then let the pipeline empty in mid-image
			if ($urandom_range(0, 49) == 0)
				wait_for_results();
			send_pixel(random_pixel());
		end
	endtask

	// 3x3 image: one interior pixel, extreme differences both ways
	task automatic test_smallest_image();
		logic signed [PIX_W-1:0] img[9];
		img = '{16'sh0000, 16'sh7FFF, 16'shFFFF,
			16'sh8000, 16'sh0005, 16'sh7FFF,
			16'sh0001, 16'sh8000, 16'sh0064};
		set_geometry(16'd3, 16'd3);
		foreach (img[k])
			send_pixel(img[k]);
	endtask

	// tallest line count, then shrink both registers in mid-line
	task automatic test_mid_image_change();
		set_geometry(16'd4, 16'hFFFF);
		repeat (15)
			send_pixel(random_pixel());
		wait_for_results();
		// column counter now past the new last column, line past the new last line
		write_reg(REG_LINE_LENGTH, 16'd3);
		write_reg(REG_LINE_COUNT, 16'd3);
		send_pixel(random_pixel());
	endtask

	// upper length bits dropped by the 11-bit field; count raised to the minimum
	task automatic test_widest_line();
		set_geometry(16'hF805, 16'd1);
		send_random_image();
	endtask

	task automatic test_random_images();
		int               sent;
		int               r;
		logic [CFG_W-1:0] len_word, cnt_word;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				len_word = CFG_W'($urandom_range(3, 10));
			else if (r == 7)
				len_word = CFG_W'($urandom_range(0, 2));
			else if (r == 8)
				len_word = {5'($urandom_range(1, 31)), 11'($urandom_range(3, 10))};
			else
				len_word = CFG_W'($urandom_range(11, 24));
			r = $urandom_range(0, 9);
			if (r < 7)
				cnt_word = CFG_W'($urandom_range(3, 6));
			else if (r < 9)
				cnt_word = CFG_W'($urandom_range(0, 2));
			else
				cnt_word = CFG_W'($urandom_range(7, 12));
			set_geometry(len_word, cnt_word);
			sender_quiet = ($urandom_range(0, 3) == 0);
			receiver_quiet = ($urandom_range(0, 3) == 0);
			sent += eff_length() * eff_count();
			send_random_image();
		end
	endtask

	initial begin
		foreach (older_line[k]) begin
			older_line[k] = '0;
			newer_line[k] = '0;
		end
		prev_pixel[0] = '0;
		prev_pixel[1] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_smallest_image();
		test_mid_image_change();
		test_widest_line();
		test_random_images();

		wait_for_results();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: central_difference_gradient_unit.f
design/cdg_pkg.sv
design/cdg_line_mem.sv
design/cdg_seq.sv
design/central_difference_gradient_unit.sv
tb/tb_central_difference_gradient_unit.sv
